FILE: rtl/arpc_pkg.sv
// Shared types and constants for the ARP responder with IP-to-MAC cache.
// Holds frame header constants, result codes, controller states and the
// command/status structs between the controller and the datapath.
package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(CACHE_ENTRIES + 1);
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;
    localparam logic [ADDR_W-1:0] ADDR_OWN_IP = 4'd0;

    localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  HLEN_ETH      = 8'd6;
    localparam logic [7:0]  PLEN_IPV4     = 8'd4;

    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_HIT   = 2'd2;
    localparam logic [1:0] KIND_MISS  = 2'd3;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_step;
        logic write_entry;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic frame_ok;
        logic op_rep;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/arpc_ctrl.sv
// Controller state machine for the ARP responder: sequences decode, cache
// scan, cache write and result load. Depends on arpc_pkg.
module arpc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  arpc_pkg::sts_t sts,
    output arpc_pkg::cmd_t cmd
);
    import arpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // lookups and accepted replies need the cache walk
                if (sts.is_lookup || (sts.frame_ok && sts.op_rep))
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = sts.is_lookup ? ST_RESULT : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/arpc_dp.sv
// Datapath for the ARP responder: config registers, item capture, cache
// RAM walk, cache update and the output register. Depends on arpc_pkg, arpc_ram.
module arpc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [arpc_pkg::DATA_W-1:0]   pwdata,
    output logic [arpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input item fields
    input  logic                          req_type,
    input  logic [10:0]                   frame_length,
    input  logic [15:0]                   hw_type,
    input  logic [15:0]                   proto_type,
    input  logic [7:0]                    hw_len,
    input  logic [7:0]                    proto_len,
    input  logic [15:0]                   opcode,
    input  logic [arpc_pkg::MAC_W-1:0]    sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]     sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]     target_ip,
    input  logic [arpc_pkg::IP_W-1:0]     lookup_ip,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    result_kind,
    output logic [1:0]                    out_opcode,
    output logic [arpc_pkg::MAC_W-1:0]    out_sender_mac,
    output logic [arpc_pkg::IP_W-1:0]     out_sender_ip,
    output logic [arpc_pkg::MAC_W-1:0]    out_target_mac,
    output logic [arpc_pkg::IP_W-1:0]     out_target_ip,
    output logic [arpc_pkg::MAC_W-1:0]    resolved_mac,
    output logic                          cache_written,
    output logic                          cache_full,
    // controller link
    input  arpc_pkg::cmd_t                cmd,
    output arpc_pkg::sts_t                sts
);
    import arpc_pkg::*;

    // configuration
    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic             cfg_wr_c;

    // captured item
    logic             is_lookup_reg;
    logic             ok_reg;
    logic             op_req_reg;
    logic             op_rep_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  sip_reg;
    logic [IP_W-1:0]  key_reg;
    logic             frame_ok_c;

    // cache walk
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [MAC_W-1:0] found_mac_reg;
    logic             more_c;
    logic             issue_c;
    logic             match_c;
    logic             room_c;
    logic [ENTRY_W-1:0] rd_data;
    logic             wr_en_c;
    logic [IDX_W-1:0] wr_addr_c;
    logic             written_reg;
    logic             full_reg;

    // result
    logic             out_valid_reg;
    logic [1:0]       kind_c;
    logic [1:0]       op_c;
    logic [MAC_W-1:0] smac_c;
    logic [IP_W-1:0]  sip_c;
    logic [MAC_W-1:0] tmac_c;
    logic [IP_W-1:0]  tip_c;
    logic [MAC_W-1:0] resolved_c;
    logic             written_c;
    logic             full_c;
    logic             hit_c;
    logic [1:0]       kind_reg;
    logic [1:0]       op_reg;
    logic [MAC_W-1:0] osmac_reg;
    logic [IP_W-1:0]  osip_reg;
    logic [MAC_W-1:0] otmac_reg;
    logic [IP_W-1:0]  otip_reg;
    logic [MAC_W-1:0] resolved_reg;
    logic             owritten_reg;
    logic             ofull_reg;

    // configuration port: address zero is own_ip, any other selects own_mac
    assign pready   = 1'b1;
    assign cfg_wr_c = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr == ADDR_OWN_IP)
        begin
            prdata = {{(DATA_W-IP_W){1'b0}}, own_ip_reg};
        end
        else
        begin
            prdata = {{(DATA_W-MAC_W){1'b0}}, own_mac_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_wr_c)
        begin
            if (paddr == ADDR_OWN_IP)
            begin
                own_ip_reg <= pwdata[IP_W-1:0];
            end
            else
            begin
                own_mac_reg <= pwdata[MAC_W-1:0];
            end
        end
    end

    // header and target check on the incoming beat
    assign frame_ok_c = (frame_length >= MIN_FRAME_LEN) && (hw_type == HTYPE_ETH) &&
                        (proto_type == PTYPE_IPV4) && (hw_len == HLEN_ETH) &&
                        (proto_len == PLEN_IPV4) && (target_ip == own_ip_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            is_lookup_reg <= req_type;
            ok_reg        <= frame_ok_c;
            op_req_reg    <= (opcode == {14'd0, OP_REQUEST});
            op_rep_reg    <= (opcode == {14'd0, OP_REPLY});
            smac_reg      <= sender_mac;
            sip_reg       <= sender_ip;
            key_reg       <= req_type ? lookup_ip : sender_ip;
        end
    end

    // cache walk: one read issued per cycle, compared in the following cycle on the registered read data
    assign more_c  = (idx_reg < cnt_reg);
    assign issue_c = cmd.scan_step && !found_reg && more_c;
    assign match_c = pend_reg && !found_reg && (rd_data[ENTRY_W-1:MAC_W] == key_reg);
    assign room_c  = (cnt_reg < CNT_W'(CACHE_ENTRIES));

    assign wr_en_c   = cmd.write_entry && (found_reg || room_c);
    assign wr_addr_c = found_reg ? found_idx_reg : cnt_reg[IDX_W-1:0];

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_cache (
        .clk   (clk),
        .we    (wr_en_c),
        .waddr (wr_addr_c),
        .wdata ({key_reg, smac_reg}),
        .re    (issue_c),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            written_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            pend_reg <= issue_c;
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (issue_c)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match_c)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.load_item)
            begin
                written_reg <= 1'b0;
                full_reg    <= 1'b0;
            end
            else if (cmd.write_entry)
            begin
                if (found_reg)
                begin
                    written_reg <= 1'b1;
                end
                else if (room_c)
                begin
                    // append at the fill mark
                    cnt_reg     <= cnt_reg + 1'b1;
                    written_reg <= 1'b1;
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_c)
        begin
            pend_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (match_c)
        begin
            found_idx_reg <= pend_idx_reg;
            found_mac_reg <= rd_data[MAC_W-1:0];
        end
    end

    // result assembly
    assign hit_c = found_reg && (found_mac_reg != MAC_BCAST);

    always_comb
    begin
        kind_c     = KIND_NONE;
        op_c       = '0;
        smac_c     = '0;
        sip_c      = '0;
        tmac_c     = '0;
        tip_c      = '0;
        resolved_c = '0;
        written_c  = 1'b0;
        full_c     = 1'b0;
        if (is_lookup_reg)
        begin
            if (hit_c)
            begin
                kind_c     = KIND_HIT;
                resolved_c = found_mac_reg;
            end
            else
            begin
                // a cached broadcast address counts as a miss
                kind_c     = KIND_MISS;
                op_c       = OP_REQUEST;
                smac_c     = own_mac_reg;
                sip_c      = own_ip_reg;
                tmac_c     = MAC_BCAST;
                tip_c      = key_reg;
                resolved_c = MAC_BCAST;
            end
        end
        else if (ok_reg && op_req_reg)
        begin
            kind_c = KIND_REPLY;
            op_c   = OP_REPLY;
            smac_c = own_mac_reg;
            sip_c  = own_ip_reg;
            tmac_c = smac_reg;
            tip_c  = sip_reg;
        end
        else
        begin
            written_c = written_reg;
            full_c    = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            kind_reg     <= kind_c;
            op_reg       <= op_c;
            osmac_reg    <= smac_c;
            osip_reg     <= sip_c;
            otmac_reg    <= tmac_c;
            otip_reg     <= tip_c;
            resolved_reg <= resolved_c;
            owritten_reg <= written_c;
            ofull_reg    <= full_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign out_opcode     = op_reg;
    assign out_sender_mac = osmac_reg;
    assign out_sender_ip  = osip_reg;
    assign out_target_mac = otmac_reg;
    assign out_target_ip  = otip_reg;
    assign resolved_mac   = resolved_reg;
    assign cache_written  = owritten_reg;
    assign cache_full     = ofull_reg;

    assign sts.is_lookup = is_lookup_reg;
    assign sts.frame_ok  = ok_reg;
    assign sts.op_rep    = op_rep_reg;
    assign sts.scan_done = found_reg || (!pend_reg && !more_c);
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

FILE: rtl/arp_responder_with_cache.sv
// ARP responder with a 16-entry IP-to-MAC cache.
// Input beat on in_valid/in_ready: req_type 0 is a parsed ARP frame,
// req_type 1 resolves lookup_ip. Each item gives exactly one result beat
// on out_valid/out_ready, with result_kind none, reply, hit or miss.
// own_ip (address 0) and own_mac (any other address) are written over
// the APB-style port; pready is always high, reads return the register.
// A frame that needs no cache access passes from accept through the decode
// and result states to out_valid. Lookups and accepted replies walk the
// cache RAM, one entry per cycle with the compare on the registered read
// data in the following cycle, up to the first match or the fill mark;
// a cache update then passes through the write state.
// One item is in flight at a time; in_ready rises again once the result
// is in the output register, so the next item can enter in the same cycle
// that out_valid rises, while that result still waits for out_ready.
// Reset clears the config registers, the fill count and the output valid;
// the cache contents need no clearing because only filled entries are read.
// A stalled receiver holds the result; the block finishes its next item
// and then waits for the output register to drain.
module arp_responder_with_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [arpc_pkg::DATA_W-1:0]   pwdata,
    output logic [arpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [10:0]                   frame_length,
    input  logic [15:0]                   hw_type,
    input  logic [15:0]                   proto_type,
    input  logic [7:0]                    hw_len,
    input  logic [7:0]                    proto_len,
    input  logic [15:0]                   opcode,
    input  logic [arpc_pkg::MAC_W-1:0]    sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]     sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]     target_ip,
    input  logic [arpc_pkg::IP_W-1:0]     lookup_ip,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    result_kind,
    output logic [1:0]                    out_opcode,
    output logic [arpc_pkg::MAC_W-1:0]    out_sender_mac,
    output logic [arpc_pkg::IP_W-1:0]     out_sender_ip,
    output logic [arpc_pkg::MAC_W-1:0]    out_target_mac,
    output logic [arpc_pkg::IP_W-1:0]     out_target_ip,
    output logic [arpc_pkg::MAC_W-1:0]    resolved_mac,
    output logic                          cache_written,
    output logic                          cache_full
);
    import arpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_type       (req_type),
        .frame_length   (frame_length),
        .hw_type        (hw_type),
        .proto_type     (proto_type),
        .hw_len         (hw_len),
        .proto_len      (proto_len),
        .opcode         (opcode),
        .sender_mac     (sender_mac),
        .sender_ip      (sender_ip),
        .target_ip      (target_ip),
        .lookup_ip      (lookup_ip),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .out_opcode     (out_opcode),
        .out_sender_mac (out_sender_mac),
        .out_sender_ip  (out_sender_ip),
        .out_target_mac (out_target_mac),
        .out_target_ip  (out_target_ip),
        .resolved_mac   (resolved_mac),
        .cache_written  (cache_written),
        .cache_full     (cache_full),
        .cmd            (cmd),
        .sts            (sts)
    );

    // one item in flight: no second accept right after a beat is taken
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(cache_written && cache_full))
        else $error("cache written and cache full flagged together");

    a_flags_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cache_written || cache_full) |-> result_kind == KIND_NONE)
        else $error("cache flag raised on a result that sends a frame");

    a_hit_not_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_HIT) |-> resolved_mac != MAC_BCAST)
        else $error("lookup hit returned the broadcast address");

endmodule
